FILE: hdl/sip_pkg.sv
// Package for the segment intersection point unit.
// Default widths used by the top level; no dependencies.
`default_nettype none
package sip_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 32;
endpackage
`default_nettype wire

FILE: hdl/sip_div.sv
// Pipelined restoring divider, one quotient bit per stage, sign-magnitude.
// Depends on sip_pkg.
`default_nettype none
module sip_div #(
    parameter int NW = 53,
    parameter int KW = 35,
    parameter int QW = 32,
    parameter int FW = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [KW-1:0] den,
    output logic          [QW-1:0]    quo,
    output logic                      neg
);
    import sip_pkg::*;

    localparam int W = KW + QW;

    logic [W-1:0]  rem_reg [0:QW];
    logic [KW-1:0] dvs_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic          neg_reg [0:QW];

    logic [NW-1:0] nmag;
    logic [KW-1:0] dmag;

    assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
    assign dmag = den[KW-1] ? KW'(-den) : KW'(den);

    // load: remainder starts as the scaled numerator magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= W'(nmag) << FW;
            dvs_reg[0] <= dmag;
            quo_reg[0] <= '0;
            neg_reg[0] <= num[NW-1] ^ den[KW-1];
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int I = QW - 1 - k;
        logic [W-1:0] dsh;
        logic         take;
        assign dsh  = W'(dvs_reg[k]) << I;
        assign take = rem_reg[k] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? rem_reg[k] - dsh : rem_reg[k];
                quo_reg[k+1] <= take ? quo_reg[k] | (QW'(1) << I) : quo_reg[k];
                dvs_reg[k+1] <= dvs_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign neg = neg_reg[QW];
endmodule
`default_nettype wire

FILE: hdl/segment_intersection_point_unit.sv
// Segment intersection point unit: proper-crossing test and crossing point.
// Depends on sip_pkg and sip_div.
//
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word, in order, through four front stages for the
// differences, products, cross products and numerator terms, a load stage
// and one stage per quotient bit in the divider, and the output register. A
// stalled output holds the whole pipeline. No hit gives hit = 0 and a zero
// point; the point is truncated toward zero and saturated to 32 bits.
`default_nettype none
module segment_intersection_point_unit #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up
    input  wire logic [8*COORD_BITS-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // cross_x, cross_y from the lowest bit up
    output logic [2*sip_pkg::OUT_BITS-1:0] m_tdata,
    // hit
    output logic                         m_tuser
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int P  = 2 * D;
    localparam int K  = 2 * D + 1;
    localparam int NN = 3 * C + 5;
    localparam int Q  = C + FRAC_BITS;
    localparam int SW = (Q > 33) ? Q : 33;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic signed [C-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = s_tdata[0*C +: C];
    assign ay = s_tdata[1*C +: C];
    assign bx = s_tdata[2*C +: C];
    assign by = s_tdata[3*C +: C];
    assign cx = s_tdata[4*C +: C];
    assign cy = s_tdata[5*C +: C];
    assign dx = s_tdata[6*C +: C];
    assign dy = s_tdata[7*C +: C];

    // stage 1: differences
    logic                v1_reg;
    logic signed [C-1:0] ax1_reg, ay1_reg;
    logic signed [D-1:0] abx1_reg, aby1_reg, cdx1_reg, cdy1_reg;
    logic signed [D-1:0] bcx1_reg, bcy1_reg, acx1_reg, acy1_reg;
    logic signed [D-1:0] cax1_reg, cay1_reg, dax1_reg, day1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            abx1_reg <= D'(bx) - D'(ax);
            aby1_reg <= D'(by) - D'(ay);
            cdx1_reg <= D'(dx) - D'(cx);
            cdy1_reg <= D'(dy) - D'(cy);
            bcx1_reg <= D'(bx) - D'(cx);
            bcy1_reg <= D'(by) - D'(cy);
            acx1_reg <= D'(ax) - D'(cx);
            acy1_reg <= D'(ay) - D'(cy);
            cax1_reg <= D'(cx) - D'(ax);
            cay1_reg <= D'(cy) - D'(ay);
            dax1_reg <= D'(dx) - D'(ax);
            day1_reg <= D'(dy) - D'(ay);
        end
    end

    // stage 2: products
    logic                v2_reg;
    logic signed [C-1:0] ax2_reg, ay2_reg;
    logic signed [D-1:0] abx2_reg, aby2_reg;
    logic signed [P-1:0] p_reg [0:11];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            abx2_reg  <= abx1_reg;
            aby2_reg  <= aby1_reg;
            p_reg[0]  <= cdx1_reg * bcy1_reg;
            p_reg[1]  <= cdy1_reg * bcx1_reg;
            p_reg[2]  <= cdx1_reg * acy1_reg;
            p_reg[3]  <= cdy1_reg * acx1_reg;
            p_reg[4]  <= abx1_reg * cay1_reg;
            p_reg[5]  <= aby1_reg * cax1_reg;
            p_reg[6]  <= abx1_reg * day1_reg;
            p_reg[7]  <= aby1_reg * dax1_reg;
            p_reg[8]  <= cax1_reg * cdy1_reg;
            p_reg[9]  <= cay1_reg * cdx1_reg;
            p_reg[10] <= abx1_reg * cdy1_reg;
            p_reg[11] <= aby1_reg * cdx1_reg;
        end
    end

    // stage 3: cross products and side test
    logic signed [K-1:0] s1v, s2v, s3v, s4v;
    logic                hit_next;
    assign s1v = K'(p_reg[0]) - K'(p_reg[1]);
    assign s2v = K'(p_reg[2]) - K'(p_reg[3]);
    assign s3v = K'(p_reg[4]) - K'(p_reg[5]);
    assign s4v = K'(p_reg[6]) - K'(p_reg[7]);
    assign hit_next =
        ((s1v > 0 && s2v < 0) || (s1v < 0 && s2v > 0)) &&
        ((s3v > 0 && s4v < 0) || (s3v < 0 && s4v > 0));

    logic                v3_reg, hit3_reg;
    logic signed [C-1:0] ax3_reg, ay3_reg;
    logic signed [D-1:0] abx3_reg, aby3_reg;
    logic signed [K-1:0] num3_reg, den3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit3_reg <= hit_next;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            abx3_reg <= abx2_reg;
            aby3_reg <= aby2_reg;
            num3_reg <= K'(p_reg[8]) - K'(p_reg[9]);
            den3_reg <= K'(p_reg[10]) - K'(p_reg[11]);
        end
    end

    // stage 4: numerator terms a*den and num*delta
    logic                 v4_reg, hit4_reg;
    logic signed [K-1:0]  den4_reg;
    logic signed [NN-1:0] mxa_reg, mxb_reg, mya_reg, myb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit4_reg <= hit3_reg;
            den4_reg <= den3_reg;
            mxa_reg  <= NN'(ax3_reg) * NN'(den3_reg);
            mxb_reg  <= NN'(num3_reg) * NN'(abx3_reg);
            mya_reg  <= NN'(ay3_reg) * NN'(den3_reg);
            myb_reg  <= NN'(num3_reg) * NN'(aby3_reg);
        end
    end

    logic signed [NN-1:0] nx, ny;
    assign nx = mxa_reg + mxb_reg;
    assign ny = mya_reg + myb_reg;

    logic [Q-1:0] qx, qy;
    logic         negx, negy;

    sip_div #(.NW(NN), .KW(K), .QW(Q), .FW(FRAC_BITS)) u_div_x (
        .clk(clk), .en(adv), .num(nx), .den(den4_reg),
        .quo(qx), .neg(negx)
    );

    sip_div #(.NW(NN), .KW(K), .QW(Q), .FW(FRAC_BITS)) u_div_y (
        .clk(clk), .en(adv), .num(ny), .den(den4_reg),
        .quo(qy), .neg(negy)
    );

    // valid and hit travel alongside the divider stages
    logic vsh_reg [0:Q];
    logic hsh_reg [0:Q];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hsh_reg[0] <= hit4_reg;
            for (int i = 0; i < Q; i++)
            begin
                hsh_reg[i+1] <= hsh_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            m_tvalid <= 1'b0;
            for (int i = 0; i <= Q; i++)
            begin
                vsh_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg     <= s_tvalid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            vsh_reg[0] <= v4_reg;
            for (int i = 0; i < Q; i++)
            begin
                vsh_reg[i+1] <= vsh_reg[i];
            end
            m_tvalid <= vsh_reg[Q];
        end
    end

    // apply sign and saturate to the output width
    localparam logic [SW-1:0] LIM_NEG = SW'(64'd2147483648);
    localparam logic [SW-1:0] LIM_POS = SW'(64'd2147483647);

    logic [SW-1:0]       qxe, qye;
    logic [OUT_BITS-1:0] ox, oy;
    assign qxe = SW'(qx);
    assign qye = SW'(qy);

    always_comb
    begin
        if (negx)
            ox = (qxe > LIM_NEG) ? OUT_BITS'(LIM_NEG) : OUT_BITS'(SW'(0) - qxe);
        else
            ox = (qxe > LIM_POS) ? OUT_BITS'(LIM_POS) : OUT_BITS'(qxe);
        if (negy)
            oy = (qye > LIM_NEG) ? OUT_BITS'(LIM_NEG) : OUT_BITS'(SW'(0) - qye);
        else
            oy = (qye > LIM_POS) ? OUT_BITS'(LIM_POS) : OUT_BITS'(qye);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tuser <= hsh_reg[Q];
            m_tdata <= hsh_reg[Q] ? {oy, ox} : '0;
        end
    end

    a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("point not zero on a miss");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v4_reg) && $stable(vsh_reg[Q]) && $stable(m_tuser))
        else $error("pipeline moved during stall");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vsh_reg[Q] |=> m_tvalid)
        else $error("word lost at output");
endmodule
`default_nettype wire
